FILE: rtl/core/pec_pkg.sv
// ----------------------------------------------------------------------------
// Polygon edge clipper package
// Shared types, constants and register indexes of the edge clipper.
// ----------------------------------------------------------------------------
package pec_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_END_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_END_Y   = 2'd3;

  localparam int EDGE_START_X_RST = 0;
  localparam int EDGE_START_Y_RST = 0;
  localparam int EDGE_END_X_RST   = 1000;
  localparam int EDGE_END_Y_RST   = 0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_OPS,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT_X,
    ST_EMIT_P,
    ST_EMIT_M
  } state_e;

  typedef enum logic [1:0] {
    EMIT_VERTEX,
    EMIT_CROSS,
    EMIT_MARKER
  } emit_sel_e;

  typedef struct packed {
    logic      load_in;
    logic      load_ops;
    logic      load_prod;
    logic      div_init;
    logic      div_step;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic p_inside;
    logic s_inside;
    logic prime;
    logic closing;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/pec_vertex_if.sv
// ----------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel that carries one polygon vertex and its flags.
// ----------------------------------------------------------------------------
interface pec_vertex_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          prime;
  logic                          closing;

  modport source (output valid, vertex_x, vertex_y, prime, closing, input ready);
  modport sink   (input valid, vertex_x, vertex_y, prime, closing, output ready);
endinterface

FILE: rtl/core/pec_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one clipped vertex or an end marker.
// ----------------------------------------------------------------------------
interface pec_result_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          has_vertex;
  logic                          polygon_done;

  modport source (output valid, out_x, out_y, has_vertex, polygon_done, input ready);
  modport sink   (input valid, out_x, out_y, has_vertex, polygon_done, output ready);
endinterface

FILE: rtl/core/pec_dpath.sv
// ----------------------------------------------------------------------------
// Edge clipper datapath
// Edge registers, vertex registers, inside tests, crossing multiplier,
// restoring divider, saturation and the output register.
// ----------------------------------------------------------------------------
module pec_dpath #(
  parameter int unsigned COORD_WIDTH = pec_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pec_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]             cfg_wdata_i,
  input  logic signed [COORD_WIDTH-1:0]      in_x_i,
  input  logic signed [COORD_WIDTH-1:0]      in_y_i,
  input  logic                               in_prime_i,
  input  logic                               in_closing_i,
  input  pec_pkg::cmd_t                      cmd_i,
  output pec_pkg::sts_t                      sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [COORD_WIDTH-1:0]      out_x_o,
  output logic signed [COORD_WIDTH-1:0]      out_y_o,
  output logic                               out_has_vertex_o,
  output logic                               out_done_o
);
  import pec_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned QW = CW + 2;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = CW + 4;

  localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  logic signed [CW-1:0] esx_q, esy_q, eex_q, eey_q;
  logic signed [CW-1:0] prev_x_q, prev_y_q;
  logic signed [CW-1:0] p_x_q, p_y_q, s_x_q, s_y_q;
  logic                 prime_q, closing_q;

  // configuration and vertex registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esx_q    <= CW'(EDGE_START_X_RST);
      esy_q    <= CW'(EDGE_START_Y_RST);
      eex_q    <= CW'(EDGE_END_X_RST);
      eey_q    <= CW'(EDGE_END_Y_RST);
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EDGE_START_X: esx_q <= cfg_wdata_i;
          CFG_EDGE_START_Y: esy_q <= cfg_wdata_i;
          CFG_EDGE_END_X:   eex_q <= cfg_wdata_i;
          CFG_EDGE_END_Y:   eey_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.load_in) begin
        prev_x_q <= in_x_i;
        prev_y_q <= in_y_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      p_x_q     <= in_x_i;
      p_y_q     <= in_y_i;
      s_x_q     <= prev_x_q;
      s_y_q     <= prev_y_q;
      prime_q   <= in_prime_i;
      closing_q <= in_closing_i;
    end
  end

  // inside tests
  logic p_in, s_in;

  assign p_in = (eex_q > esx_q && p_y_q >= esy_q) || (eex_q < esx_q && p_y_q <= esy_q) ||
                (eey_q > esy_q && p_x_q <= eex_q) || (eey_q < esy_q && p_x_q >= eex_q);
  assign s_in = (eex_q > esx_q && s_y_q >= esy_q) || (eex_q < esx_q && s_y_q <= esy_q) ||
                (eey_q > esy_q && s_x_q <= eex_q) || (eey_q < esy_q && s_x_q >= eex_q);

  // crossing operands
  logic                 hz_w;
  logic signed [DW-1:0] sx_e, sy_e, px_e, py_e, esx_e, esy_e;
  logic signed [DW-1:0] num_w, span_w, den_w;
  logic [DW-1:0]        mag_a_d, mag_b_d, den_mag_d;

  assign hz_w  = (esy_q == eey_q);
  assign sx_e  = {s_x_q[CW-1], s_x_q};
  assign sy_e  = {s_y_q[CW-1], s_y_q};
  assign px_e  = {p_x_q[CW-1], p_x_q};
  assign py_e  = {p_y_q[CW-1], p_y_q};
  assign esx_e = {esx_q[CW-1], esx_q};
  assign esy_e = {esy_q[CW-1], esy_q};

  assign num_w  = hz_w ? (esy_e - sy_e) : (esx_e - sx_e);
  assign span_w = hz_w ? (px_e - sx_e) : (py_e - sy_e);
  assign den_w  = hz_w ? (py_e - sy_e) : (px_e - sx_e);

  assign mag_a_d   = num_w[DW-1]  ? unsigned'(-num_w)  : unsigned'(num_w);
  assign mag_b_d   = span_w[DW-1] ? unsigned'(-span_w) : unsigned'(span_w);
  assign den_mag_d = den_w[DW-1]  ? unsigned'(-den_w)  : unsigned'(den_w);

  logic [DW-1:0]        mag_a_q, mag_b_q, den_q;
  logic                 neg_q, dz_q, hz_q;
  logic signed [CW-1:0] base_q;
  logic [PW-1:0]        prod_q;
  logic [DW-1:0]        rem_q;
  logic [QW-1:0]        quo_q;
  logic                 ovf_q;

  logic [CW-1:0]        prod_hi;
  logic [DW:0]          trial, trial_sub;
  logic                 ge;

  assign prod_hi   = prod_q[PW-1:QW];
  assign trial     = {rem_q, quo_q[QW-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ops) begin
      mag_a_q <= mag_a_d;
      mag_b_q <= mag_b_d;
      den_q   <= den_mag_d;
      neg_q   <= num_w[DW-1] ^ span_w[DW-1] ^ den_w[DW-1];
      dz_q    <= (den_w == '0);
      hz_q    <= hz_w;
      base_q  <= hz_w ? s_x_q : s_y_q;
    end
    if (cmd_i.load_prod) begin
      prod_q <= {{DW{1'b0}}, mag_a_q} * {{DW{1'b0}}, mag_b_q};
    end
    if (cmd_i.div_init) begin
      ovf_q <= {1'b0, prod_hi} >= den_q;
      rem_q <= {1'b0, prod_hi};
      quo_q <= prod_q[QW-1:0];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[QW-2:0], ge};
      rem_q <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
    end
  end

  // crossing coordinate: base +/- quotient, saturated
  logic signed [SW-1:0] q_s, base_s, sum_s;
  logic signed [CW-1:0] cr_w;

  assign q_s    = signed'({2'b00, quo_q});
  assign base_s = SW'(base_q);
  assign sum_s  = base_s + (neg_q ? -q_s : q_s);

  always_comb begin
    if (dz_q) begin
      cr_w = base_q;
    end else if (ovf_q) begin
      cr_w = neg_q ? CMIN[CW-1:0] : CMAX[CW-1:0];
    end else if (sum_s > CMAX) begin
      cr_w = CMAX[CW-1:0];
    end else if (sum_s < CMIN) begin
      cr_w = CMIN[CW-1:0];
    end else begin
      cr_w = sum_s[CW-1:0];
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_done_o <= cmd_i.emit_last;
      case (cmd_i.emit_sel)
        EMIT_VERTEX: begin
          out_x_o          <= p_x_q;
          out_y_o          <= p_y_q;
          out_has_vertex_o <= 1'b1;
        end
        EMIT_CROSS: begin
          out_x_o          <= hz_q ? cr_w : esx_q;
          out_y_o          <= hz_q ? esy_q : cr_w;
          out_has_vertex_o <= 1'b1;
        end
        default: begin
          out_x_o          <= '0;
          out_y_o          <= '0;
          out_has_vertex_o <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.p_inside = p_in;
  assign sts_o.s_inside = s_in;
  assign sts_o.prime    = prime_q;
  assign sts_o.closing  = closing_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/core/pec_ctrl.sv
// ----------------------------------------------------------------------------
// Edge clipper controller
// Sequences accept, classification, multiply, divide and result emission.
// ----------------------------------------------------------------------------
module pec_ctrl #(
  parameter int unsigned DIV_STEPS = pec_pkg::COORD_WIDTH_DEF + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pec_pkg::sts_t sts_i,
  output pec_pkg::cmd_t cmd_o
);
  import pec_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.prime) begin
          state_d = ST_IDLE;
        end else if (sts_i.p_inside && sts_i.s_inside) begin
          state_d = ST_EMIT_P;
        end else if (!sts_i.p_inside && !sts_i.s_inside) begin
          state_d = sts_i.closing ? ST_EMIT_M : ST_IDLE;
        end else begin
          state_d = ST_OPS;
        end
      end
      ST_OPS:      state_d = ST_MUL;
      ST_MUL:      state_d = ST_DIV_INIT;
      ST_DIV_INIT: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_EMIT_X;
        end
      end
      ST_EMIT_X: begin
        if (sts_i.out_free) begin
          state_d = sts_i.p_inside ? ST_EMIT_P : ST_IDLE;
        end
      end
      ST_EMIT_P, ST_EMIT_M: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.emit_sel   = EMIT_MARKER;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_OPS:      cmd_o.load_ops  = 1'b1;
      ST_MUL:      cmd_o.load_prod = 1'b1;
      ST_DIV_INIT: cmd_o.div_init  = 1'b1;
      ST_DIV:      cmd_o.div_step  = 1'b1;
      ST_EMIT_X: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_sel  = EMIT_CROSS;
        cmd_o.emit_last = sts_i.closing && !sts_i.p_inside;
      end
      ST_EMIT_P: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_sel  = EMIT_VERTEX;
        cmd_o.emit_last = sts_i.closing;
      end
      ST_EMIT_M: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_sel  = EMIT_MARKER;
        cmd_o.emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/polygon_edge_clipper.sv
// ----------------------------------------------------------------------------
// Polygon edge clipper
// One Sutherland-Hodgman stage: clips a vertex stream against one boundary
// edge held in configuration registers.
//
//   channel    dir  handshake     payload
//   vertex_i   in   valid/ready   vertex_x, vertex_y, prime, closing
//   result_o   out  valid/ready   out_x, out_y, has_vertex, polygon_done
//   cfg        in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// A priming vertex, or a vertex that emits nothing, returns to idle after
// classification; a vertex that emits only itself or an end marker goes
// straight to emission. A vertex that crosses the edge runs the multiply
// and the bit-serial divider of COORD_WIDTH + 2 steps, emits the crossing
// point and then, when it lies inside, the vertex itself. One vertex is in work
// at a time. The output register holds a result until its transfer and
// stalls the sequencer only when a second result is due. Reset restores the
// edge registers and zeroes the stored previous vertex.
// ----------------------------------------------------------------------------
module polygon_edge_clipper #(
  parameter int unsigned COORD_WIDTH = pec_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pec_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata_i,
  pec_vertex_if.sink                    vertex_i,
  pec_result_if.source                  result_o
);
  import pec_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pec_ctrl #(
    .DIV_STEPS (COORD_WIDTH + 2)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vertex_i.valid),
    .in_ready_o (vertex_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pec_dpath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_x_i           (vertex_i.vertex_x),
    .in_y_i           (vertex_i.vertex_y),
    .in_prime_i       (vertex_i.prime),
    .in_closing_i     (vertex_i.closing),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .out_x_o          (result_o.out_x),
    .out_y_o          (result_o.out_y),
    .out_has_vertex_o (result_o.has_vertex),
    .out_done_o       (result_o.polygon_done)
  );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Polygon edge clipper testbench
// Streams primed polygons, and some runs of randomly flagged vertices, through
// the clipper under a series of boundary edges (bottom, top, left, right,
// diagonal, degenerate, extreme). Each accepted vertex is clipped in a local
// Sutherland-Hodgman model. Every result transfer is compared field by field
// with the oldest predicted vertex or end marker, while both channels idle and
// stall at random.
module testbench;
  import pec_pkg::*;

  localparam int unsigned CW       = COORD_WIDTH_DEF;
  localparam int          SETTLE   = 2 * CW + 8;
  localparam int          QUIET_MAX = 4000;
  localparam int          PHASE_ITEMS = 184;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = coord_t'((longint'(1) << (CW - 1)) - 1);
  localparam coord_t COORD_MIN = coord_t'(-(longint'(1) << (CW - 1)));

  typedef struct {
    coord_t x;
    coord_t y;
    logic   prime;
    logic   closing;
  } vertex_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   has_vertex;
    logic   polygon_done;
  } clip_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CW-1:0]   cfg_wdata_i;

  pec_vertex_if #(.COORD_WIDTH(CW)) vtx_if ();
  pec_result_if #(.COORD_WIDTH(CW)) res_if ();

  polygon_edge_clipper #(.COORD_WIDTH(CW)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .vertex_i    (vtx_if),
    .result_o    (res_if)
  );

  vertex_t pending_vertices[$];
  clip_t   expected_clips[$];

  coord_t edge_sx = coord_t'(EDGE_START_X_RST);
  coord_t edge_sy = coord_t'(EDGE_START_Y_RST);
  coord_t edge_ex = coord_t'(EDGE_END_X_RST);
  coord_t edge_ey = coord_t'(EDGE_END_Y_RST);
  coord_t prev_x  = '0;
  coord_t prev_y  = '0;

  int mismatches   = 0;
  int quiet_cycles = 0;
  int vtx_taken    = 0;
  int vtx_mark     = 0;
  int items_pushed = 0;
  int src_gap_pct  = 0;
  int snk_stall_pct = 0;

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic bit is_inside(coord_t x, coord_t y);
    return (edge_ex > edge_sx && y >= edge_sy) || (edge_ex < edge_sx && y <= edge_sy) ||
           (edge_ey > edge_sy && x <= edge_ex) || (edge_ey < edge_sy && x >= edge_ex);
  endfunction

  // base + num * span / den, truncated toward zero; base on a zero divisor
  function automatic coord_t cross_coord(longint base, longint num, longint span,
                                         longint den);
    if (den == 0) return clamp_coord(base);
    return clamp_coord(base + (num * span) / den);
  endfunction

  function automatic void push_clip(coord_t x, coord_t y, logic has_vertex);
    clip_t c;
    c.x = x;
    c.y = y;
    c.has_vertex = has_vertex;
    c.polygon_done = 1'b0;
    expected_clips.insert(expected_clips.size(), c);
  endfunction

  function automatic void clip_vertex(vertex_t v);
    coord_t sx, sy, cx, cy;
    bit     p_in, s_in;
    int     n_before;
    sx = prev_x;
    sy = prev_y;
    prev_x = v.x;
    prev_y = v.y;
    if (v.prime) return;
    n_before = expected_clips.size();
    p_in = is_inside(v.x, v.y);
    s_in = is_inside(sx, sy);
    if (p_in != s_in) begin
      if (edge_sy == edge_ey) begin
        cy = edge_sy;
        cx = cross_coord(sx, longint'(edge_sy) - sy, longint'(v.x) - sx,
                         longint'(v.y) - sy);
      end else begin
        cx = edge_sx;
        cy = cross_coord(sy, longint'(edge_sx) - sx, longint'(v.y) - sy,
                         longint'(v.x) - sx);
      end
      push_clip(cx, cy, 1'b1);
    end
    if (p_in) push_clip(v.x, v.y, 1'b1);
    if (v.closing) begin
      if (expected_clips.size() == n_before) push_clip('0, '0, 1'b0);
      expected_clips[expected_clips.size() - 1].polygon_done = 1'b1;
    end
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  function automatic coord_t pick_coord(coord_t center);
    int span;
    case ($urandom_range(9))
      0: return coord_t'($urandom);
      1: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
      default: begin
        span = 1 << $urandom_range(0, 12);
        return clamp_coord(longint'(center) + longint'($urandom_range(0, 2 * span)) - span);
      end
    endcase
  endfunction

  task automatic push_vertex(coord_t x, coord_t y, logic prime, logic closing);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.prime = prime;
    v.closing = closing;
    pending_vertices.insert(pending_vertices.size(), v);
    items_pushed++;
  endtask

  task automatic add_polygon();
    coord_t xs[8];
    coord_t ys[8];
    int     n;
    n = $urandom_range(3, 8);
    for (int i = 0; i < n; i++) begin
      xs[i] = pick_coord(edge_ex);
      ys[i] = pick_coord(edge_sy);
    end
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < n; i++) push_vertex(xs[i], ys[i], $urandom_range(1), $urandom_range(1));
    end else begin
      push_vertex(xs[n-1], ys[n-1], 1'b1, 1'b0);
      for (int i = 0; i < n; i++) push_vertex(xs[i], ys[i], 1'b0, i == n - 1);
    end
  endtask

  // hold until every vertex is taken and every result is back, then let
  // a vertex that produces nothing finish
  task automatic drain();
    while (pending_vertices.size() != 0 || expected_clips.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, coord_t value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic write_edge(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    cfg_write(CFG_EDGE_START_X, sx);
    cfg_write(CFG_EDGE_START_Y, sy);
    cfg_write(CFG_EDGE_END_X, ex);
    cfg_write(CFG_EDGE_END_Y, ey);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // source and sink drivers
  always @(negedge clk_i) begin
    if (vtx_if.valid && vtx_taken == vtx_mark) begin
      // hold the current item until its transfer
    end else if (pending_vertices.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
      vtx_if.valid    <= 1'b1;
      vtx_if.vertex_x <= pending_vertices[0].x;
      vtx_if.vertex_y <= pending_vertices[0].y;
      vtx_if.prime    <= pending_vertices[0].prime;
      vtx_if.closing  <= pending_vertices[0].closing;
      vtx_mark = vtx_taken;
    end else begin
      vtx_if.valid <= 1'b0;
    end
    res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // monitor: config shadow, prediction and result check
  always @(posedge clk_i) begin
    vertex_t v;
    clip_t   e;
    if (rst_ni) begin
      quiet_cycles++;
      if (cfg_we_i) begin
        quiet_cycles = 0;
        case (cfg_idx_i)
          CFG_EDGE_START_X: edge_sx = coord_t'(cfg_wdata_i);
          CFG_EDGE_START_Y: edge_sy = coord_t'(cfg_wdata_i);
          CFG_EDGE_END_X:   edge_ex = coord_t'(cfg_wdata_i);
          CFG_EDGE_END_Y:   edge_ey = coord_t'(cfg_wdata_i);
          default: ;
        endcase
      end
      if (res_if.valid && res_if.ready) begin
        quiet_cycles = 0;
        if (expected_clips.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result x=%0d y=%0d has_vertex=%0b done=%0b", $time,
                   res_if.out_x, res_if.out_y, res_if.has_vertex, res_if.polygon_done);
        end else begin
          e = expected_clips.pop_front();
          compare_field("out_x", e.x, res_if.out_x);
          compare_field("out_y", e.y, res_if.out_y);
          compare_field("has_vertex", e.has_vertex, res_if.has_vertex);
          compare_field("polygon_done", e.polygon_done, res_if.polygon_done);
        end
      end
      if (vtx_if.valid && vtx_if.ready) begin
        quiet_cycles = 0;
        vtx_taken++;
        v.x = vtx_if.vertex_x;
        v.y = vtx_if.vertex_y;
        v.prime = vtx_if.prime;
        v.closing = vtx_if.closing;
        void'(pending_vertices.pop_front());
        clip_vertex(v);
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_MAX);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    coord_t edge_set[9][4];
    int     phase_start;
    edge_set = '{'{0, 0, 1000, 0}, '{500, -200, -700, -200}, '{300, -1000, 300, 2000},
                 '{-400, 900, -400, -900}, '{-32768, -32768, 32767, 32767},
                 '{100, 100, 100, 100}, '{32767, 32767, -32768, -32768},
                 '{-32768, 32767, 32767, 32767}, '{0, -32768, 0, 32767}};
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_EDGE_START_X;
    cfg_wdata_i     = '0;
    vtx_if.valid    = 1'b0;
    vtx_if.vertex_x = '0;
    vtx_if.vertex_y = '0;
    vtx_if.prime    = 1'b0;
    vtx_if.closing  = 1'b0;
    res_if.ready    = 1'b0;
    src_gap_pct     = 10;
    snk_stall_pct   = 79;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // bottom edge out of reset: inside when y >= 0; pause mid-polygon
    push_vertex(50, -20, 1'b1, 1'b0);
    push_vertex(0, 10, 1'b0, 1'b0);
    drain();
    push_vertex(100, 10, 1'b0, 1'b0);
    push_vertex(50, -20, 1'b0, 1'b1);
    // all outside: end marker only
    push_vertex(5, -1, 1'b1, 1'b0);
    push_vertex(-5, -1, 1'b0, 1'b0);
    push_vertex(5, -1, 1'b0, 1'b1);
    // corner coordinates
    push_vertex(COORD_MAX, COORD_MIN, 1'b1, 1'b0);
    push_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    push_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    push_vertex(COORD_MIN, COORD_MAX, 1'b0, 1'b0);
    push_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b1);
    // prime with closing, then a closing vertex with no prime
    push_vertex(7, 7, 1'b1, 1'b1);
    push_vertex(-3, 0, 1'b0, 1'b1);
    drain();

    // diagonal edge: crossings with a zero divisor both ways, then one without
    write_edge(0, 0, 100, 100);
    push_vertex(200, -50, 1'b1, 1'b0);
    push_vertex(200, 50, 1'b0, 1'b0);
    push_vertex(200, -50, 1'b0, 1'b1);
    push_vertex(-20, -30, 1'b1, 1'b0);
    push_vertex(150, -30, 1'b0, 1'b1);

    for (int k = 0; k < 9; k++) begin
      drain();
      write_edge(edge_set[k][0], edge_set[k][1], edge_set[k][2], edge_set[k][3]);
      if (k < 3) begin
        src_gap_pct   = 10;
        snk_stall_pct = 79;
      end else if (k < 6) begin
        src_gap_pct   = 79;
        snk_stall_pct = 10;
      end else begin
        src_gap_pct   = 0;
        snk_stall_pct = 0;
      end
      phase_start = items_pushed;
      while (items_pushed - phase_start < PHASE_ITEMS) add_polygon();
    end

    drain();
    if (mismatches == 0 && expected_clips.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pec_pkg.sv
rtl/core/pec_vertex_if.sv
rtl/core/pec_result_if.sv
rtl/core/pec_dpath.sv
rtl/core/pec_ctrl.sv
rtl/core/polygon_edge_clipper.sv
verif/testbench.sv
